// ===== hw/rtl/pbs_pkg.sv =====
// Package for the packed bit stack: sizes, operation and status codes,
// payload and internal structs. Depends on nothing.
package pbs_pkg;

    // Storage geometry; WORD_BITS is a power of two.
    localparam int WORD_BITS   = 64;
    localparam int STORE_WORDS = 256;
    localparam int WB_LOG      = $clog2(WORD_BITS);
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int CAP_BITS    = WORD_BITS * STORE_WORDS;
    localparam int PTR_W       = ADDR_W + WB_LOG + 1;

    // Fixed field widths of the ports.
    localparam int IN_WORD_W = 64;
    localparam int IDX_W     = 14;
    localparam int LEN_OUT_W = 15;

    localparam logic [2:0] KIND_APPEND_BIT  = 3'd0;
    localparam logic [2:0] KIND_APPEND_WORD = 3'd1;
    localparam logic [2:0] KIND_POP_BIT     = 3'd2;
    localparam logic [2:0] KIND_READ_BIT    = 3'd3;
    localparam logic [2:0] KIND_READ_WORD   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ROOM   = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;
    localparam logic [1:0] ST_PAST_END  = 2'd3;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 bit_in;
        logic [IN_WORD_W-1:0] word_in;
        logic [IDX_W-1:0]     bit_index;
    } t_in_item;

    typedef struct packed {
        logic                 bit_out;
        logic [IN_WORD_W-1:0] word_out;
        logic [LEN_OUT_W-1:0] length_out;
        logic [1:0]           status;
    } t_out_item;

    // Operation context captured at accept, used in the execute cycle.
    typedef struct packed {
        logic [2:0]           kind;
        logic [1:0]           status;
        logic                 bit_in;
        logic [WORD_BITS-1:0] word;
        logic [WB_LOG-1:0]    pos;
        logic                 need_hi;
        logic                 avail_lt;
        logic [WB_LOG-1:0]    avail_lo;
    } t_op;

    // Datapath results for the execute and second-write cycles.
    typedef struct packed {
        logic                 wr_en;
        logic [WORD_BITS-1:0] wr_data;
        logic                 hi_en;
        logic [WORD_BITS-1:0] hi_data;
        logic                 bit_out;
        logic [WORD_BITS-1:0] word_out;
    } t_dp_res;

endpackage

// ===== hw/rtl/pbs_word_ram.sv =====
// Generic word memory: one write port, two read ports, registered read data.
// Depends on nothing.
module pbs_word_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== hw/rtl/pbs_dp.sv =====
// Bit merge and extract datapath of the packed bit stack.
// Depends on pbs_pkg.
module pbs_dp (
    input  pbs_pkg::t_op                        i_op,
    input  logic [pbs_pkg::WORD_BITS-1:0]       i_rd_a,
    input  logic [pbs_pkg::WORD_BITS-1:0]       i_rd_b,
    output pbs_pkg::t_dp_res                    o_res
);
    import pbs_pkg::*;

    localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1);

    logic                 ok;
    logic [WB_LOG:0]      comp;
    logic [WORD_BITS-1:0] rw;

    assign ok   = (i_op.status == ST_OK);
    assign comp = (WB_LOG+1)'(WORD_BITS) - (WB_LOG+1)'(i_op.pos);

    // Assemble a word that starts mid-word; clip past the stored end.
    always_comb begin
        rw = i_rd_a >> i_op.pos;
        if (i_op.need_hi) begin
            rw = rw | (i_rd_b << comp);
        end
        if (i_op.avail_lt) begin
            rw = rw & ((ONE_W << i_op.avail_lo) - ONE_W);
        end
    end

    always_comb begin
        o_res          = '0;
        o_res.hi_data  = i_op.word >> comp;
        case (i_op.kind)
            KIND_APPEND_BIT: begin
                o_res.wr_en   = ok;
                o_res.wr_data = (i_op.pos == '0) ? WORD_BITS'(i_op.bit_in)
                              : (i_rd_a | (WORD_BITS'(i_op.bit_in) << i_op.pos));
            end
            KIND_APPEND_WORD: begin
                o_res.wr_en   = ok;
                o_res.wr_data = (i_op.pos == '0) ? i_op.word
                              : (i_rd_a | (i_op.word << i_op.pos));
                o_res.hi_en   = ok && (i_op.pos != '0);
            end
            KIND_POP_BIT: begin
                o_res.wr_en   = ok;
                o_res.bit_out = ok & i_rd_a[i_op.pos];
                o_res.wr_data = i_rd_a & ((ONE_W << i_op.pos) - ONE_W);
            end
            KIND_READ_BIT: begin
                o_res.bit_out = ok & i_rd_a[i_op.pos];
            end
            KIND_READ_WORD: begin
                o_res.word_out = ok ? rw : '0;
            end
            default: begin
                o_res.wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/packed_bit_stack.sv =====
// Top level of the packed bit stack: sequencer, length counter, word memory
// and result register. Depends on pbs_pkg, pbs_word_ram and pbs_dp.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       source     o_out_valid / i_out_stall o_out_data (t_out_item)
//
// A transaction passes through the accept state, which issues the memory
// reads, and the execute state, which merges, writes back and loads the
// result register. An unaligned word append adds a second-write state for
// its high half, since the memory has a single write port. The registered
// read data of the memory and the write-before-next-read order set this sequence.
// Reset clears the length counter, the sequencer and the result valid; the
// memory is not cleared, a word is always written whole before it is read.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits in execute until the register frees up.
module packed_bit_stack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pbs_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pbs_pkg::t_out_item o_out_data
);
    import pbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HIGH
    } t_state;

    t_state              r_state;
    logic [PTR_W-1:0]    r_len;
    logic [PTR_W-1:0]    r_len_new;
    t_op                 r_op;
    logic [ADDR_W-1:0]   r_addr_a;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic                in_acc;
    logic                out_free;
    logic [PTR_W:0]      len_inc1;
    logic [PTR_W:0]      len_incw;
    logic [PTR_W-1:0]    last;
    logic [PTR_W-1:0]    idx;
    logic [PTR_W-1:0]    rid;
    logic [PTR_W-1:0]    used;
    logic [PTR_W-1:0]    avail;
    logic                idx_bad;
    t_op                 n_op;
    logic [PTR_W-1:0]    n_len;
    logic [ADDR_W-1:0]   n_addr_a;
    logic [ADDR_W-1:0]   n_addr_b;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] rd_a;
    logic [WORD_BITS-1:0] rd_b;
    t_dp_res             dp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Decode the incoming transaction against the current length.
    assign len_inc1 = (PTR_W+1)'(r_len) + (PTR_W+1)'(1);
    assign len_incw = (PTR_W+1)'(r_len) + (PTR_W+1)'(WORD_BITS);
    assign last     = r_len - PTR_W'(1);
    assign idx      = PTR_W'(i_in_data.bit_index);
    assign idx_bad  = (idx >= r_len);
    assign rid      = idx >> WB_LOG;
    assign used     = (r_len + PTR_W'(WORD_BITS - 1)) >> WB_LOG;
    assign avail    = r_len - idx;
    assign n_addr_b = ADDR_W'(rid + PTR_W'(1));

    always_comb begin
        n_op          = '0;
        n_op.kind     = i_in_data.kind;
        n_op.bit_in   = i_in_data.bit_in;
        n_op.word     = WORD_BITS'(i_in_data.word_in);
        n_op.status   = ST_OK;
        n_op.pos      = r_len[WB_LOG-1:0];
        n_op.need_hi  = (idx[WB_LOG-1:0] != '0) && ((rid + PTR_W'(1)) < used);
        n_op.avail_lt = (avail < PTR_W'(WORD_BITS));
        n_op.avail_lo = avail[WB_LOG-1:0];
        n_len         = r_len;
        n_addr_a      = ADDR_W'(r_len >> WB_LOG);
        case (i_in_data.kind)
            KIND_APPEND_BIT: begin
                if (len_inc1 > (PTR_W+1)'(CAP_BITS)) begin
                    n_op.status = ST_NO_ROOM;
                end else begin
                    n_len = PTR_W'(len_inc1);
                end
            end
            KIND_APPEND_WORD: begin
                if (len_incw > (PTR_W+1)'(CAP_BITS)) begin
                    n_op.status = ST_NO_ROOM;
                end else begin
                    n_len = PTR_W'(len_incw);
                end
            end
            KIND_POP_BIT: begin
                n_op.pos = last[WB_LOG-1:0];
                n_addr_a = ADDR_W'(last >> WB_LOG);
                if (r_len == '0) begin
                    n_op.status = ST_POP_EMPTY;
                end else begin
                    n_len = last;
                end
            end
            KIND_READ_BIT, KIND_READ_WORD: begin
                n_op.pos = idx[WB_LOG-1:0];
                n_addr_a = ADDR_W'(rid);
                if (idx_bad) begin
                    n_op.status = ST_PAST_END;
                end
            end
            default: begin
                n_op.status = ST_OK;
            end
        endcase
    end

    // Write back in execute; the high half of an unaligned word follows.
    assign mem_we    = ((r_state == S_EXEC) && out_free && dp.wr_en) || (r_state == S_HIGH);
    assign mem_waddr = (r_state == S_HIGH) ? (r_addr_a + ADDR_W'(1)) : r_addr_a;
    assign mem_wdata = (r_state == S_HIGH) ? dp.hi_data : dp.wr_data;

    pbs_word_ram #(
        .DEPTH (STORE_WORDS),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (in_acc),
        .i_raddr_a (n_addr_a),
        .i_raddr_b (n_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    pbs_dp u_dp (
        .i_op   (r_op),
        .i_rd_a (rd_a),
        .i_rd_b (rd_b),
        .o_res  (dp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once the sink takes it, unless a new one loads.
            if (r_out_valid && !i_out_stall && !((r_state == S_EXEC) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= n_op;
                        r_len_new <= n_len;
                        r_addr_a  <= n_addr_a;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // Hold here while the result register is occupied.
                    if (out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.bit_out    <= dp.bit_out;
                        r_out_data.word_out   <= IN_WORD_W'(dp.word_out);
                        r_out_data.length_out <= LEN_OUT_W'(r_len_new);
                        r_out_data.status     <= r_op.status;
                        r_len                 <= r_len_new;
                        r_state               <= dp.hi_en ? S_HIGH : S_IDLE;
                    end
                end
                S_HIGH: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/pbs_checker.sv =====
// Port-level checker for the packed bit stack, bound to the top level.
// Depends on pbs_pkg and packed_bit_stack.
module pbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input pbs_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pbs_pkg::t_out_item o_out_data
);
    import pbs_pkg::*;

    // A stalled result stays valid.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // One transaction at a time: input stalls right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction accepted during execute");

    // A pop on empty reports an empty stack.
    a_pop_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_POP_EMPTY))
            |-> (o_out_data.length_out == LEN_OUT_W'(0)))
        else $error("pop on empty with nonzero length");

endmodule

bind packed_bit_stack pbs_checker u_pbs_checker (.*);
